@@ hw/rtl/ost_pkg.sv @@
// Shared types and constants for the overlap score top-K block.
`timescale 1ns / 1ps

package ost_pkg;

    // Table depth and size of the item id space.
    localparam int TOP_COUNT  = 50;
    localparam int ITEM_SPACE = 65536;

    // Field widths.
    localparam int ITEM_W  = 16;
    localparam int UID_W   = 24;
    localparam int SCORE_W = 16;
    localparam int RANK_W  = 6;
    localparam int SPACE_W = 21;

    // Bitmap geometry: rows of 32 membership bits.
    localparam int BM_W     = 32;
    localparam int BM_BIT_W = $clog2(BM_W);
    localparam int BM_ROWS  = (ITEM_SPACE + BM_W - 1) / BM_W;
    localparam int BM_AW    = (BM_ROWS > 1) ? $clog2(BM_ROWS) : 1;

    // Table geometry.
    localparam int TB_AW  = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int FILL_W = $clog2(TOP_COUNT + 1);

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_USER = 2'd1,
        ACT_END  = 2'd2,
        ACT_READ = 2'd3
    } t_action;

    localparam logic KIND_SCORE = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    typedef struct packed {
        logic [UID_W-1:0]   uid;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [BM_AW-1:0] addr;
        logic [BM_W-1:0]  wdata;
    } t_bm_req;

    typedef struct packed {
        logic             rd_en;
        logic [TB_AW-1:0] rd_addr;
        logic             wr_en;
        logic [TB_AW-1:0] wr_addr;
        t_entry           wdata;
    } t_tb_req;

endpackage

@@ hw/rtl/ost_bitmap_ram.sv @@
// Reference membership bitmap, one row of bits per address, registered read.
`timescale 1ns / 1ps

module ost_bitmap_ram
    import ost_pkg::*;
(
    input  logic            i_clk,
    input  t_bm_req         i_req,
    output logic [BM_W-1:0] o_rdata
);

    logic [BM_W-1:0] mem [BM_ROWS];
    logic [BM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ost_table_ram.sv @@
// Top-K table storage, one user id and score per entry, registered read.
`timescale 1ns / 1ps

module ost_table_ram
    import ost_pkg::*;
(
    input  logic    i_clk,
    input  t_tb_req i_req,
    output t_entry  o_rdata
);

    t_entry mem [TOP_COUNT];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ost_seq.sv @@
// Sequencer: bitmap clear, scoring, top-K insertion by a shared compare, readout.
`timescale 1ns / 1ps

module ost_seq
    import ost_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [39:0]     s_axis_tdata,   // item_id, user_id
    input  logic [1:0]      s_axis_tuser,   // action
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [47:0]     m_axis_tdata,   // user_id_out, score, rank, entry_valid
    output logic            m_axis_tuser,   // kind
    output logic            m_axis_tlast,   // last
    output t_bm_req         o_bm_req,
    input  logic [BM_W-1:0] i_bm_rdata,
    output t_tb_req         o_tb_req,
    input  t_entry          i_tb_rdata
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD_WR,
        S_USER_CNT,
        S_FULL_CHK,
        S_INS_RD,
        S_INS_CMP,
        S_EMIT,
        S_RO_RD,
        S_RO_OUT
    } t_state;

    t_state              r_state;
    logic [BM_AW-1:0]    r_clr;
    logic [ITEM_W-1:0]   r_item;
    logic [UID_W-1:0]    r_uid;
    logic [SCORE_W-1:0]  r_score;
    logic [SCORE_W-1:0]  r_sc;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   r_i;
    logic [TB_AW-1:0]    r_k;
    logic                r_kept;

    logic                r_m_valid;
    logic [UID_W-1:0]    r_m_uid;
    logic [SCORE_W-1:0]  r_m_score;
    logic [RANK_W-1:0]   r_m_rank;
    logic                r_m_entry_valid;
    logic                r_m_kind;
    logic                r_m_last;

    logic [ITEM_W-1:0]   w_in_item;
    logic [UID_W-1:0]    w_in_uid;
    t_action             w_in_action;
    logic                w_accept;
    logic                w_out_free;
    logic                w_m_load;
    logic [FILL_W-1:0]   w_im1;
    logic                w_item_in_range;
    logic                w_item_hit;
    logic                w_tb_less;
    logic                w_ro_in_fill;
    logic [FILL_W-1:0]   w_fill_inc;
    t_entry              w_new_entry;

    assign w_in_item   = s_axis_tdata[ITEM_W-1:0];
    assign w_in_uid    = s_axis_tdata[ITEM_W +: UID_W];
    assign w_in_action = t_action'(s_axis_tuser);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_m_load      = ((r_state == S_EMIT) || (r_state == S_RO_OUT)) && w_out_free;

    assign w_im1           = r_i - FILL_W'(1);
    assign w_item_in_range = (SPACE_W'(r_item) < SPACE_W'(ITEM_SPACE));
    assign w_item_hit      = w_item_in_range && i_bm_rdata[r_item[BM_BIT_W-1:0]];
    assign w_tb_less       = (i_tb_rdata.score < r_sc);
    assign w_ro_in_fill    = (FILL_W'(r_k) < r_fill);
    assign w_fill_inc      = (r_fill == FILL_W'(TOP_COUNT)) ? r_fill : r_fill + FILL_W'(1);
    assign w_new_entry     = '{uid: r_uid, score: r_sc};

    // Memory requests follow directly from the current step.
    always_comb begin
        o_bm_req = '0;
        o_tb_req = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_bm_req.wr_en = 1'b1;
                o_bm_req.addr  = r_clr;
            end
            S_IDLE: begin
                if (w_accept && (w_in_action == ACT_LOAD || w_in_action == ACT_USER)) begin
                    o_bm_req.rd_en = 1'b1;
                    o_bm_req.addr  = BM_AW'(w_in_item >> BM_BIT_W);
                end
                if (w_accept && w_in_action == ACT_END && r_fill == FILL_W'(TOP_COUNT)) begin
                    o_tb_req.rd_en   = 1'b1;
                    o_tb_req.rd_addr = TB_AW'(TOP_COUNT - 1);
                end
            end
            S_LOAD_WR: begin
                o_bm_req.wr_en = w_item_in_range;
                o_bm_req.addr  = BM_AW'(r_item >> BM_BIT_W);
                o_bm_req.wdata = i_bm_rdata | (BM_W'(1) << r_item[BM_BIT_W-1:0]);
            end
            S_INS_RD: begin
                if (r_i == '0) begin
                    o_tb_req.wr_en   = 1'b1;
                    o_tb_req.wr_addr = '0;
                    o_tb_req.wdata   = w_new_entry;
                end else begin
                    o_tb_req.rd_en   = 1'b1;
                    o_tb_req.rd_addr = w_im1[TB_AW-1:0];
                end
            end
            S_INS_CMP: begin
                // A lower entry moves down one place; otherwise the new user lands here.
                o_tb_req.wr_en   = 1'b1;
                o_tb_req.wr_addr = r_i[TB_AW-1:0];
                o_tb_req.wdata   = w_tb_less ? i_tb_rdata : w_new_entry;
            end
            S_RO_RD: begin
                o_tb_req.rd_en   = 1'b1;
                o_tb_req.rd_addr = r_k;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_score   <= '0;
            r_fill    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_m_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BM_AW'(1);
                    if (r_clr == BM_AW'(BM_ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_item <= w_in_item;
                        r_uid  <= w_in_uid;
                        unique case (w_in_action)
                            ACT_LOAD: r_state <= S_LOAD_WR;
                            ACT_USER: r_state <= S_USER_CNT;
                            ACT_END: begin
                                r_sc    <= r_score;
                                r_score <= '0;
                                if (r_fill == FILL_W'(TOP_COUNT)) begin
                                    r_state <= S_FULL_CHK;
                                end else begin
                                    r_i     <= r_fill;
                                    r_state <= S_INS_RD;
                                end
                            end
                            ACT_READ: begin
                                r_k     <= '0;
                                r_state <= S_RO_RD;
                            end
                        endcase
                    end
                end
                S_LOAD_WR: begin
                    r_state <= S_IDLE;
                end
                S_USER_CNT: begin
                    if (w_item_hit && r_score != '1) begin
                        r_score <= r_score + SCORE_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_FULL_CHK: begin
                    // With a full table the user is kept only if the lowest entry scores less.
                    if (w_tb_less) begin
                        r_i     <= FILL_W'(TOP_COUNT - 1);
                        r_state <= S_INS_RD;
                    end else begin
                        r_i     <= '0;
                        r_kept  <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                S_INS_RD: begin
                    if (r_i == '0) begin
                        r_kept  <= 1'b1;
                        r_fill  <= w_fill_inc;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (w_tb_less) begin
                        r_i     <= w_im1;
                        r_state <= S_INS_RD;
                    end else begin
                        r_kept  <= 1'b1;
                        r_fill  <= w_fill_inc;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_m_kind        <= KIND_SCORE;
                        r_m_uid         <= r_uid;
                        r_m_score       <= r_sc;
                        r_m_rank        <= RANK_W'(r_i);
                        r_m_entry_valid <= r_kept;
                        r_m_last        <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                S_RO_RD: begin
                    r_state <= S_RO_OUT;
                end
                S_RO_OUT: begin
                    if (w_out_free) begin
                        r_m_kind        <= KIND_ENTRY;
                        r_m_uid         <= w_ro_in_fill ? i_tb_rdata.uid : '0;
                        r_m_score       <= w_ro_in_fill ? i_tb_rdata.score : '0;
                        r_m_rank        <= RANK_W'(r_k);
                        r_m_entry_valid <= w_ro_in_fill;
                        r_m_last        <= (r_k == TB_AW'(TOP_COUNT - 1));
                        if (r_k == TB_AW'(TOP_COUNT - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + TB_AW'(1);
                            r_state <= S_RO_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_entry_valid, r_m_rank, r_m_score, r_m_uid};
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;

endmodule

@@ hw/rtl/overlap_score_top_k_top.sv @@
// Top level of the overlap score top-K block: sequencer, bitmap and table memories.
//
//  Channel  Dir  tdata (low bit up)                            tuser        tlast
//  s_axis   in   item_id[15:0], user_id[39:16]                 action[1:0]  -
//  m_axis   out  user_id_out[23:0], score[39:24], rank[45:40], kind         last
//                entry_valid[46], zero[47]
//
// A reference load or user item reads one bitmap row, then applies the update.
// End of user reads each lower entry and moves it down one place until the user lands,
// and then emits the result; a full table first checks its lowest entry, and a user
// that is not kept only emits its result. Output stalls can delay the emit.
// Readout reads each table entry, then emits it; output stalls can hold it.
// After reset the bitmap is cleared one row per cycle, all 2048 rows, before input is taken.
// The input accepts a new item while the last result still waits in the output register.
`timescale 1ns / 1ps

module overlap_score_top_k_top
    import ost_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // item_id, user_id
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // user_id_out, score, rank, entry_valid
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);

    t_bm_req         w_bm_req;
    logic [BM_W-1:0] w_bm_rdata;
    t_tb_req         w_tb_req;
    t_entry          w_tb_rdata;

    ost_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_bm_req      (w_bm_req),
        .i_bm_rdata    (w_bm_rdata),
        .o_tb_req      (w_tb_req),
        .i_tb_rdata    (w_tb_rdata)
    );

    ost_bitmap_ram u_bitmap (
        .i_clk   (i_clk),
        .i_req   (w_bm_req),
        .o_rdata (w_bm_rdata)
    );

    ost_table_ram u_table (
        .i_clk   (i_clk),
        .i_req   (w_tb_req),
        .o_rdata (w_tb_rdata)
    );

endmodule

@@ test/tb_overlap_score_checker.sv @@
// Result checker for the overlap score top-K block: predicts every result and compares it.
`timescale 1ns / 1ps

module tb_overlap_score_checker
    import ost_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,    // item_id, user_id
    input  logic [1:0]  i_s_tuser,    // action
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,    // user_id_out, score, rank, entry_valid
    input  logic        i_m_tuser,    // kind
    input  logic        i_m_tlast,    // last
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic               kind;
        logic [UID_W-1:0]   uid;
        logic [SCORE_W-1:0] score;
        logic [RANK_W-1:0]  rank;
        logic               kept;
        logic               last;
    } t_result;

    // Own copy of the block state.
    bit                 member_map [ITEM_SPACE];
    logic [SCORE_W-1:0] user_score;
    t_entry             ranking [TOP_COUNT];
    int                 ranked;

    t_result awaited_results [$];
    int      mismatch_count;

    function automatic void score_and_rank(input t_action act, input logic [ITEM_W-1:0] item,
                                           input logic [UID_W-1:0] uid);
        int slot;
        int tail;
        case (act)
            ACT_LOAD: begin
                if (int'(item) < ITEM_SPACE) member_map[item] = 1'b1;
            end
            ACT_USER: begin
                if (int'(item) < ITEM_SPACE && member_map[item] && user_score != '1)
                    user_score++;
            end
            ACT_END: begin
                // The new user goes below every entry with an equal or higher score.
                slot = 0;
                while (slot < ranked && ranking[slot].score >= user_score) slot++;
                if (slot < TOP_COUNT) begin
                    tail = (ranked < TOP_COUNT) ? ranked : TOP_COUNT - 1;
                    for (int i = tail; i > slot; i--) ranking[i] = ranking[i-1];
                    ranking[slot].uid   = uid;
                    ranking[slot].score = user_score;
                    if (ranked < TOP_COUNT) ranked++;
                    awaited_results.push_back('{KIND_SCORE, uid, user_score, RANK_W'(slot),
                                                1'b1, 1'b1});
                end else begin
                    awaited_results.push_back('{KIND_SCORE, uid, user_score, '0, 1'b0, 1'b1});
                end
                user_score = '0;
            end
            default: begin
                for (int k = 0; k < TOP_COUNT; k++) begin
                    if (k < ranked)
                        awaited_results.push_back('{KIND_ENTRY, ranking[k].uid,
                                                    ranking[k].score, RANK_W'(k), 1'b1,
                                                    k == TOP_COUNT - 1});
                    else
                        awaited_results.push_back('{KIND_ENTRY, '0, '0, RANK_W'(k), 1'b0,
                                                    k == TOP_COUNT - 1});
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            foreach (member_map[i]) member_map[i] = 1'b0;
            foreach (ranking[i]) ranking[i] = '0;
            user_score = '0;
            ranked     = 0;
            awaited_results.delete();
        end else begin
            // Inputs first, so a result can never overtake the transfer that causes it.
            if (i_s_tvalid === 1'b1 && i_s_tready === 1'b1)
                score_and_rank(t_action'(i_s_tuser), i_s_tdata[15:0], i_s_tdata[39:16]);
            if (i_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
                got = '{i_m_tuser, i_m_tdata[23:0], i_m_tdata[39:24], i_m_tdata[45:40],
                        i_m_tdata[46], i_m_tlast};
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: unexpected result kind %b uid %h score %0d rank %0d",
                                  " valid %b last %b"}, $time, got.kind, got.uid, got.score,
                                 got.rank, got.kept, got.last);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.kind !== want.kind || got.uid !== want.uid ||
                        got.score !== want.score || got.rank !== want.rank ||
                        got.kept !== want.kept || got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected kind %b uid %h score %0d rank %0d valid %b last %b",
                                     want.kind, want.uid, want.score, want.rank, want.kept,
                                     want.last);
                            $display("  actual   kind %b uid %h score %0d rank %0d valid %b last %b",
                                     got.kind, got.uid, got.score, got.rank, got.kept,
                                     got.last);
                        end
                    end
                end
            end
        end
        o_pending    = awaited_results.size();
        o_fail_count = mismatch_count;
    end

endmodule

@@ test/tb_overlap_score_top_k_top.sv @@
// Testbench top for the overlap score top-K block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_overlap_score_top_k_top;
    import ost_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int cycle_count;
    bit tx_calm;
    bit rx_calm;

    logic [ITEM_W-1:0] ref_ids [$];

    overlap_score_top_k_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    tb_overlap_score_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** overlap_score_top_k_top: FAILED **");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input t_action act, input logic [ITEM_W-1:0] item,
                        input logic [UID_W-1:0] uid);
        int gap;
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {uid, item};
        s_tuser  = act;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Result side: random stalls before each transfer, with calm stretches.
    initial begin
        int stall;
        m_tready = 1'b0;
        rx_calm  = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (!(m_tvalid === 1'b1 && m_tready));
        end
    end

    initial begin
        int sent;
        int pick;
        int n;
        logic [ITEM_W-1:0] id;
        logic [UID_W-1:0]  uid;

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_LOAD;
        tx_calm     = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, empty users, id extremes, repeats, non-members and ties.
        send(ACT_READ, 16'h0000, 24'h000000);
        send(ACT_END, 16'hFFFF, 24'h000000);
        send(ACT_LOAD, 16'h0000, 24'hFFFFFF);
        send(ACT_LOAD, 16'hFFFF, 24'h000000);
        send(ACT_LOAD, 16'h5A5A, 24'h5A5A5A);
        send(ACT_USER, 16'h0000, 24'hA5A5A5);
        send(ACT_USER, 16'hFFFF, 24'h000000);
        send(ACT_USER, 16'h0000, 24'hFFFFFF);
        send(ACT_USER, 16'h0001, 24'h000000);
        send(ACT_USER, 16'hA5A5, 24'h000000);
        send(ACT_END, 16'h0000, 24'hFFFFFF);
        send(ACT_USER, 16'h5A5A, 24'h000000);
        send(ACT_END, 16'h0000, 24'h123456);
        send(ACT_END, 16'h0000, 24'h000001);
        send(ACT_READ, 16'hFFFF, 24'hFFFFFF);
        wait_idle();
        ref_ids.push_back(16'h0000);
        ref_ids.push_back(16'hFFFF);
        ref_ids.push_back(16'h5A5A);

        // Random: mostly whole user lists, with loads, readouts, stray items and drains.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                id = ITEM_W'($urandom);
                uid = UID_W'($urandom);
                send(ACT_LOAD, id, uid);
                ref_ids.push_back(id);
                sent++;
            end else if (pick < 11) begin
                id = ITEM_W'($urandom);
                uid = UID_W'($urandom);
                send(ACT_READ, id, uid);
                sent++;
            end else if (pick < 14) begin
                id = ITEM_W'($urandom);
                uid = UID_W'($urandom);
                send(t_action'($urandom_range(0, 3)), id, uid);
                sent++;
            end else if (pick < 16) begin
                wait_idle();
            end else begin
                n = $urandom_range(0, 6);
                repeat (n) begin
                    if ($urandom_range(0, 9) < 6)
                        id = ref_ids[$urandom_range(0, ref_ids.size() - 1)];
                    else
                        id = ITEM_W'($urandom);
                    uid = UID_W'($urandom);
                    send(ACT_USER, id, uid);
                    sent++;
                end
                id = ITEM_W'($urandom);
                uid = UID_W'($urandom);
                send(ACT_END, id, uid);
                sent++;
            end
        end
        send(ACT_READ, 16'h0000, 24'h000000);

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** overlap_score_top_k_top: PASSED **");
        end else begin
            $display("** overlap_score_top_k_top: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ost_pkg.sv
hw/rtl/ost_bitmap_ram.sv
hw/rtl/ost_table_ram.sv
hw/rtl/ost_seq.sv
hw/rtl/overlap_score_top_k_top.sv
test/tb_overlap_score_checker.sv
test/tb_overlap_score_top_k_top.sv
